[rtl/core/app_pkg.sv]
// Shared types, constants and tables for the autocallable path payoff block.
`default_nettype none
package app_pkg;

  localparam int MAX_OBS_DEF = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int LOG_W       = 32;
  localparam int VAR_W       = 40;
  localparam int UNI_W       = 32;
  localparam int MONEY_W     = 48;
  localparam int OBS_W       = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;

  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [31:0] LN2_HALF  = 32'd1488522236;
  localparam logic [39:0] EXP_BIAS  = 40'd595408894400;
  localparam logic [9:0]  EXP_KOFS  = 10'd200;
  localparam logic [MONEY_W-1:0] MONEY_MAX = {MONEY_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KI_LEVEL     = 3'd0,
    REG_STRIKE_LEVEL = 3'd1,
    REG_LOSS_SCALE   = 3'd2,
    REG_PAR_VALUE    = 3'd3,
    REG_PUT_STRIKE   = 3'd4,
    REG_SPOT_PV      = 3'd5,
    REG_CONTINUOUS   = 3'd6,
    REG_BRIDGE_EN    = 3'd7
  } app_reg_t;

  typedef struct packed {
    logic signed [LOG_W-1:0] ki_log_level;
    logic signed [LOG_W-1:0] strike_log_level;
    logic [MONEY_W-1:0]      loss_scale;
    logic [MONEY_W-1:0]      par_value;
    logic [MONEY_W-1:0]      put_strike_pv;
    logic [MONEY_W-1:0]      spot_pv;
    logic                    continuous_knock_in;
    logic                    bridge_enable;
  } app_cfg_t;

  typedef struct packed {
    logic signed [LOG_W-1:0] prev_log;
    logic signed [LOG_W-1:0] log_price;
    logic [VAR_W-1:0]        var_step;
    logic [UNI_W-1:0]        bridge_uniform;
    logic                    is_observation;
    logic signed [LOG_W-1:0] autocall_log_level;
    logic [MONEY_W-1:0]      coupon_value;
    logic                    last_step;
  } app_item_t;

  function automatic logic signed [35:0] poly_coef(input logic [3:0] idx);
    logic signed [35:0] c;
    case (idx)
      4'd0: c = 36'sd106522;
      4'd1: c = 36'sd852176;
      4'd2: c = 36'sd5965232;
      4'd3: c = 36'sd35791394;
      4'd4: c = 36'sd178956971;
      4'd5: c = 36'sd715827883;
      4'd6: c = 36'sd2147483648;
      4'd7: c = 36'sd4294967296;
      4'd8: c = 36'sd4294967296;
      default: c = 36'sd0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/core/app_front.sv]
// Front end: accepts substep words, advances the log price, pushes work items.
`default_nettype none
module app_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [app_pkg::LOG_W-1:0]     in_mu_step,
  input  logic signed [app_pkg::LOG_W-1:0]     in_increment,
  input  logic [app_pkg::VAR_W-1:0]            in_var_step,
  input  logic [app_pkg::UNI_W-1:0]            in_bridge_uniform,
  input  logic                                 in_is_observation,
  input  logic signed [app_pkg::LOG_W-1:0]     in_autocall_log_level,
  input  logic [app_pkg::MONEY_W-1:0]          in_coupon_value,
  input  logic                                 in_last_step,
  input  logic                                 q_full,
  output logic                                 q_push,
  output app_pkg::app_item_t                   q_item
);
  import app_pkg::*;

  logic signed [LOG_W-1:0] log_r, log_nxt;
  logic signed [LOG_W+1:0] sum;
  logic signed [LOG_W-1:0] lp;

  assign sum = {{2{log_r[LOG_W-1]}}, log_r}
             + {{2{in_mu_step[LOG_W-1]}}, in_mu_step}
             + {{2{in_increment[LOG_W-1]}}, in_increment};

  always_comb begin
    if (sum > 34'sd2147483647) begin
      lp = 32'sh7fffffff;
    end else if (sum < -34'sd2147483648) begin
      lp = 32'sh80000000;
    end else begin
      lp = sum[LOG_W-1:0];
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_item.prev_log           = log_r;
    q_item.log_price          = lp;
    q_item.var_step           = in_var_step;
    q_item.bridge_uniform     = in_bridge_uniform;
    q_item.is_observation     = in_is_observation;
    q_item.autocall_log_level = in_autocall_log_level;
    q_item.coupon_value       = in_coupon_value;
    q_item.last_step          = in_last_step;
  end

  always_comb begin
    log_nxt = log_r;
    if (q_push) begin
      log_nxt = in_last_step ? '0 : lp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_r <= '0;
    end else begin
      log_r <= log_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/core/app_queue.sv]
// Short queue of work items between the front end and the back end.
`default_nettype none
module app_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  app_pkg::app_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output app_pkg::app_item_t pop_item
);
  import app_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  app_item_t       slot_r [QUEUE_DEPTH];
  logic [AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(QUEUE_DEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_item = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/core/app_back.sv]
// Back end: knock-in, bridge test, autocall, final payoff, output register.
`default_nettype none
module app_back #(
  parameter int MAX_OBSERVATIONS = app_pkg::MAX_OBS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  app_pkg::app_cfg_t             cfg,
  input  logic                          q_valid,
  input  app_pkg::app_item_t            q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [app_pkg::MONEY_W-1:0]   out_path_value,
  output logic [app_pkg::MONEY_W-1:0]   out_put_value,
  output logic                          out_was_called,
  output logic [app_pkg::OBS_W-1:0]     out_call_observation,
  output logic                          out_knocked_in_alive
);
  import app_pkg::*;

  localparam int OCW = $clog2(MAX_OBSERVATIONS + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_PREP  = 10'b0000000010,
    S_DCHK  = 10'b0000000100,
    S_DIV   = 10'b0000001000,
    S_EXPK  = 10'b0000010000,
    S_POLY  = 10'b0000100000,
    S_SCALE = 10'b0001000000,
    S_UPD   = 10'b0010000000,
    S_MUL   = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } app_state_t;

  function automatic logic [MONEY_W-1:0] add_money(input logic [MONEY_W-1:0] a,
                                                   input logic [MONEY_W-1:0] b);
    logic [MONEY_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[MONEY_W] ? MONEY_MAX : s[MONEY_W-1:0];
  endfunction

  function automatic logic [41:0] exp_seed(input logic signed [40:0] x);
    logic signed [42:0] s;
    s = {{2{x[40]}}, x} + $signed({3'b0, EXP_BIAS}) + $signed({11'b0, LN2_HALF});
    return s[41:0];
  endfunction

  function automatic logic signed [35:0] mul_frac(input logic signed [35:0] a,
                                                  input logic signed [32:0] b);
    logic [35:0] ua;
    logic [32:0] ub;
    logic [68:0] pr;
    logic [35:0] pm;
    logic        neg;
    neg = a[35] ^ b[32];
    ua  = a[35] ? 36'(-a) : 36'(a);
    ub  = b[32] ? 33'(-b) : 33'(b);
    pr  = ua * ub;
    pm  = pr[67:32];
    return neg ? -$signed(pm) : $signed(pm);
  endfunction

  app_state_t          state_r, state_nxt;
  app_item_t           item_r, item_nxt;
  logic [5:0]          cnt_r, cnt_nxt;
  logic [63:0]         ab_r, ab_nxt;
  logic [39:0]         rem_r, rem_nxt;
  logic [36:0]         q_r, q_nxt;
  logic [41:0]         erem_r, erem_nxt;
  logic [8:0]          kk_r, kk_nxt;
  logic signed [32:0]  r_r, r_nxt;
  logic signed [35:0]  p_r, p_nxt;
  logic [63:0]         e_r, e_nxt;
  logic                esat_r, esat_nxt;
  logic                bhit_r, bhit_nxt;
  logic                efin_r, efin_nxt;
  logic                msel_r, msel_nxt;
  logic [111:0]        acc_r, acc_nxt;
  logic [MONEY_W-1:0]  ml_r, ml_nxt, ms_r, ms_nxt;

  logic                alive_r, alive_nxt;
  logic                kin_r, kin_nxt;
  logic [MONEY_W-1:0]  val_r, val_nxt;
  logic [OCW-1:0]      obsc_r, obsc_nxt;
  logic [OBS_W-1:0]    called_r, called_nxt;

  logic                ov_r, ov_nxt;
  logic [MONEY_W-1:0]  opv_r, opv_nxt, oput_r, oput_nxt;
  logic                ocall_r, ocall_nxt, okia_r, okia_nxt;
  logic [OBS_W-1:0]    oobs_r, oobs_nxt;

  logic signed [32:0]  da, db;
  logic [63:0]         ab_mul;
  logic                lvl_hit;
  logic [40:0]         dv_t;
  logic                dv_bit, dv_ge;
  logic [41:0]         lsh;
  logic                k_ge;
  logic signed [9:0]   kexp;
  logic [9:0]          nk;
  logic [34:0]         up;
  logic [127:0]        wide;
  logic [63:0]         e_c;
  logic                sat_c;
  logic [31:0]         mul_a, mul_b;
  logic [63:0]         pp;
  logic [111:0]        ppw;
  logic [MONEY_W-1:0]  mres, mop;
  logic                obs_live;
  logic [MONEY_W-1:0]  vacc;
  logic                valive, vkin;

  assign out_valid            = ov_r;
  assign out_path_value       = opv_r;
  assign out_put_value        = oput_r;
  assign out_was_called       = ocall_r;
  assign out_call_observation = oobs_r;
  assign out_knocked_in_alive = okia_r;

  assign q_pop = (state_r == S_IDLE) && q_valid;

  assign da      = {item_r.prev_log[31], item_r.prev_log}
                 - {cfg.ki_log_level[31], cfg.ki_log_level};
  assign db      = {item_r.log_price[31], item_r.log_price}
                 - {cfg.ki_log_level[31], cfg.ki_log_level};
  assign ab_mul  = da[31:0] * db[31:0];
  assign lvl_hit = item_r.log_price <= cfg.ki_log_level;

  assign dv_bit = (cnt_r >= 6'd21) ? ab_r[4'(cnt_r - 6'd21)] : 1'b0;
  assign dv_t   = {rem_r, dv_bit};
  assign dv_ge  = dv_t >= {1'b0, item_r.var_step};

  assign lsh  = 42'(LN2_Q32) << cnt_r[3:0];
  assign k_ge = erem_r >= lsh;

  assign up   = p_r[35] ? '0 : p_r[34:0];
  assign kexp = $signed({1'b0, kk_r}) - $signed(EXP_KOFS);
  assign nk   = 10'(-kexp);
  assign wide = {93'b0, up} << kexp[5:0];

  always_comb begin
    e_c   = '0;
    sat_c = 1'b0;
    if (!kexp[9]) begin
      if (kexp >= 10'sd64) begin
        sat_c = (up != '0);
      end else if (wide[127:64] != '0) begin
        sat_c = 1'b1;
      end else begin
        e_c = wide[63:0];
      end
    end else if (nk < 10'd64) begin
      e_c = {29'b0, up} >> nk[5:0];
    end
  end

  assign mop   = msel_r ? cfg.spot_pv : cfg.loss_scale;
  assign mul_a = cnt_r[1] ? {16'b0, mop[47:32]} : mop[31:0];
  assign mul_b = cnt_r[0] ? e_r[63:32] : e_r[31:0];
  assign pp    = mul_a * mul_b;

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    ppw = {48'b0, pp};
      2'd3:    ppw = {pp[47:0], 64'b0};
      default: ppw = {16'b0, pp, 32'b0};
    endcase
  end

  always_comb begin
    if (mop == '0) begin
      mres = '0;
    end else if (esat_r || (acc_nxt[111:80] != '0)) begin
      mres = MONEY_MAX;
    end else begin
      mres = acc_nxt[79:32];
    end
  end

  assign obs_live = item_r.is_observation && (obsc_r < OCW'(MAX_OBSERVATIONS));

  always_comb begin
    state_nxt  = state_r;
    item_nxt   = item_r;
    cnt_nxt    = cnt_r;
    ab_nxt     = ab_r;
    rem_nxt    = rem_r;
    q_nxt      = q_r;
    erem_nxt   = erem_r;
    kk_nxt     = kk_r;
    r_nxt      = r_r;
    p_nxt      = p_r;
    e_nxt      = e_r;
    esat_nxt   = esat_r;
    bhit_nxt   = bhit_r;
    efin_nxt   = efin_r;
    msel_nxt   = msel_r;
    acc_nxt    = acc_r;
    ml_nxt     = ml_r;
    ms_nxt     = ms_r;
    alive_nxt  = alive_r;
    kin_nxt    = kin_r;
    val_nxt    = val_r;
    obsc_nxt   = obsc_r;
    called_nxt = called_r;
    ov_nxt     = ov_r && !out_ready;
    opv_nxt    = opv_r;
    oput_nxt   = oput_r;
    ocall_nxt  = ocall_r;
    okia_nxt   = okia_r;
    oobs_nxt   = oobs_r;
    vacc       = val_r;
    valive     = alive_r;
    vkin       = kin_r;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          item_nxt  = q_item;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        ab_nxt   = ab_mul;
        bhit_nxt = 1'b0;
        if (cfg.continuous_knock_in && cfg.bridge_enable && !lvl_hit &&
            (item_r.prev_log > cfg.ki_log_level)) begin
          state_nxt = S_DCHK;
        end else begin
          state_nxt = S_UPD;
        end
      end
      S_DCHK: begin
        if (ab_r >= {8'b0, item_r.var_step, 16'b0}) begin
          state_nxt = S_UPD;
        end else begin
          rem_nxt   = ab_r[55:16];
          q_nxt     = '0;
          cnt_nxt   = 6'd36;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = dv_ge ? 40'(dv_t - {1'b0, item_r.var_step}) : dv_t[39:0];
        q_nxt   = {q_r[35:0], dv_ge};
        if (cnt_r == '0) begin
          erem_nxt  = exp_seed(-$signed({4'b0, q_nxt}));
          kk_nxt    = '0;
          cnt_nxt   = 6'd8;
          efin_nxt  = 1'b0;
          state_nxt = S_EXPK;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_EXPK: begin
        erem_nxt = k_ge ? erem_r - lsh : erem_r;
        kk_nxt   = kk_r | (k_ge ? (9'd1 << cnt_r[3:0]) : 9'd0);
        if (cnt_r == '0) begin
          r_nxt     = $signed({1'b0, erem_nxt[31:0]}) - $signed({1'b0, LN2_HALF});
          p_nxt     = poly_coef(4'd0);
          cnt_nxt   = 6'd1;
          state_nxt = S_POLY;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_POLY: begin
        p_nxt = mul_frac(p_r, r_r) + poly_coef(cnt_r[3:0]);
        if (cnt_r == 6'd8) begin
          state_nxt = S_SCALE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SCALE: begin
        if (efin_r) begin
          e_nxt     = e_c;
          esat_nxt  = sat_c;
          cnt_nxt   = '0;
          msel_nxt  = 1'b0;
          state_nxt = S_MUL;
        end else begin
          bhit_nxt  = sat_c || ({32'b0, item_r.bridge_uniform} < e_c);
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (cfg.continuous_knock_in) begin
          if (alive_r && (lvl_hit || bhit_r)) begin
            kin_nxt = 1'b1;
          end
        end else if (obs_live && alive_r && lvl_hit) begin
          kin_nxt = 1'b1;
        end
        if (obs_live) begin
          if (alive_r && (item_r.log_price >= item_r.autocall_log_level)) begin
            val_nxt    = add_money(val_r, item_r.coupon_value);
            alive_nxt  = 1'b0;
            called_nxt = OBS_W'(obsc_r);
          end
          obsc_nxt = obsc_r + 1'b1;
        end
        if (item_r.last_step) begin
          erem_nxt  = exp_seed({item_r.log_price[31], item_r.log_price, 8'b0});
          kk_nxt    = '0;
          cnt_nxt   = 6'd8;
          efin_nxt  = 1'b1;
          state_nxt = S_EXPK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MUL: begin
        acc_nxt = ((cnt_r == '0) ? 112'b0 : acc_r) + ppw;
        if (cnt_r == 6'd3) begin
          cnt_nxt = '0;
          if (msel_r) begin
            ms_nxt    = mres;
            state_nxt = S_FIN;
          end else begin
            ml_nxt   = mres;
            msel_nxt = 1'b1;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        if (!ov_r || out_ready) begin
          if (valive && vkin && (item_r.log_price < cfg.strike_log_level)) begin
            vacc = add_money(val_r, ml_r);
          end else if (valive) begin
            vacc = add_money(val_r, cfg.par_value);
          end
          ov_nxt     = 1'b1;
          opv_nxt    = vacc;
          oput_nxt   = (cfg.put_strike_pv > ms_r) ? cfg.put_strike_pv - ms_r : '0;
          ocall_nxt  = !valive;
          oobs_nxt   = valive ? '0 : called_r;
          okia_nxt   = valive && vkin;
          alive_nxt  = 1'b1;
          kin_nxt    = 1'b0;
          val_nxt    = '0;
          obsc_nxt   = '0;
          called_nxt = '0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    cnt_r   <= cnt_nxt;
    ab_r    <= ab_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    erem_r  <= erem_nxt;
    kk_r    <= kk_nxt;
    r_r     <= r_nxt;
    p_r     <= p_nxt;
    e_r     <= e_nxt;
    esat_r  <= esat_nxt;
    bhit_r  <= bhit_nxt;
    efin_r  <= efin_nxt;
    msel_r  <= msel_nxt;
    acc_r   <= acc_nxt;
    ml_r    <= ml_nxt;
    ms_r    <= ms_nxt;
    opv_r   <= opv_nxt;
    oput_r  <= oput_nxt;
    ocall_r <= ocall_nxt;
    okia_r  <= okia_nxt;
    oobs_r  <= oobs_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ov_r     <= 1'b0;
      alive_r  <= 1'b1;
      kin_r    <= 1'b0;
      val_r    <= '0;
      obsc_r   <= '0;
      called_r <= '0;
    end else begin
      state_r  <= state_nxt;
      ov_r     <= ov_nxt;
      alive_r  <= alive_nxt;
      kin_r    <= kin_nxt;
      val_r    <= val_nxt;
      obsc_r   <= obsc_nxt;
      called_r <= called_nxt;
    end
  end

`ifndef SYNTHESIS
  a_obs_bound: assert property (@(posedge clk) disable iff (!rst_n)
    obsc_r <= OCW'(MAX_OBSERVATIONS))
    else $error("observation count past limit");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < item_r.var_step))
    else $error("divider remainder not below divisor");

  a_exp_red: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXPK) |-> (erem_r < (42'(LN2_Q32) << (cnt_r[3:0] + 4'd1))))
    else $error("exponent reduction out of range");

  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) && (!ov_r || out_ready) |=> ov_r && (state_r == S_IDLE))
    else $error("result not loaded on finish");
`endif

endmodule
`default_nettype wire

[rtl/core/autocallable_path_payoff.sv]
// Top level of the autocallable path payoff block: config registers and wiring.
//
//   channel | ports                      | moves
//   in      | in_valid / in_ready        | one substep word per path step
//   out     | out_valid / out_ready      | one result word per finished path
//   cfg     | cfg_we, cfg_index, cfg_wdata | one register write per cycle
//
// A substep passes the idle, prep and update states of the back end; the bridge
// test adds a check and, where needed, the bit-serial divider and the shared
// exponential. A path's last substep adds the exponential and 32x32 multiplier.
// Reset is synchronous, active low; no clearing pass is needed.
// A 2-entry queue lets the front end keep taking words while the back end works
// or a result waits on out_ready, until the queue is full.
`default_nettype none
module autocallable_path_payoff #(
  parameter int MAX_OBSERVATIONS = app_pkg::MAX_OBS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [app_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [app_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [app_pkg::LOG_W-1:0]     in_mu_step,
  input  logic signed [app_pkg::LOG_W-1:0]     in_increment,
  input  logic [app_pkg::VAR_W-1:0]            in_var_step,
  input  logic [app_pkg::UNI_W-1:0]            in_bridge_uniform,
  input  logic                                 in_is_observation,
  input  logic signed [app_pkg::LOG_W-1:0]     in_autocall_log_level,
  input  logic [app_pkg::MONEY_W-1:0]          in_coupon_value,
  input  logic                                 in_last_step,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [app_pkg::MONEY_W-1:0]          out_path_value,
  output logic [app_pkg::MONEY_W-1:0]          out_put_value,
  output logic                                 out_was_called,
  output logic [app_pkg::OBS_W-1:0]            out_call_observation,
  output logic                                 out_knocked_in_alive
);
  import app_pkg::*;

  app_cfg_t  cfg_r, cfg_nxt;
  logic      q_push, q_full, q_pop, q_valid;
  app_item_t push_item, pop_item;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (app_reg_t'(cfg_index))
        REG_KI_LEVEL:     cfg_nxt.ki_log_level        = cfg_wdata[LOG_W-1:0];
        REG_STRIKE_LEVEL: cfg_nxt.strike_log_level    = cfg_wdata[LOG_W-1:0];
        REG_LOSS_SCALE:   cfg_nxt.loss_scale          = cfg_wdata[MONEY_W-1:0];
        REG_PAR_VALUE:    cfg_nxt.par_value           = cfg_wdata[MONEY_W-1:0];
        REG_PUT_STRIKE:   cfg_nxt.put_strike_pv       = cfg_wdata[MONEY_W-1:0];
        REG_SPOT_PV:      cfg_nxt.spot_pv             = cfg_wdata[MONEY_W-1:0];
        REG_CONTINUOUS:   cfg_nxt.continuous_knock_in = cfg_wdata[0];
        REG_BRIDGE_EN:    cfg_nxt.bridge_enable       = cfg_wdata[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  app_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_mu_step            (in_mu_step),
    .in_increment          (in_increment),
    .in_var_step           (in_var_step),
    .in_bridge_uniform     (in_bridge_uniform),
    .in_is_observation     (in_is_observation),
    .in_autocall_log_level (in_autocall_log_level),
    .in_coupon_value       (in_coupon_value),
    .in_last_step          (in_last_step),
    .q_full                (q_full),
    .q_push                (q_push),
    .q_item                (push_item)
  );

  app_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (pop_item)
  );

  app_back #(
    .MAX_OBSERVATIONS (MAX_OBSERVATIONS)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .q_valid              (q_valid),
    .q_item               (pop_item),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_path_value       (out_path_value),
    .out_put_value        (out_put_value),
    .out_was_called       (out_was_called),
    .out_call_observation (out_call_observation),
    .out_knocked_in_alive (out_knocked_in_alive)
  );

endmodule
`default_nettype wire
